// ----- hw/rtl/rss_pkg.sv -----
// Shared types, codes, constants and helper functions of the ramp/soak setpoint sequencer.
package rss_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int SECONDS_PER_HOUR = 3600;
    localparam logic [7:0] MARGIN_RESET = 8'd5;

    // Widths of the shared multiply/divide datapath.
    localparam int NUM_W     = 48;
    localparam int DEN_W     = 28;
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);

    localparam logic [2:0] KIND_PV       = 3'd0;
    localparam logic [2:0] KIND_APPEND   = 3'd1;
    localparam logic [2:0] KIND_START    = 3'd2;
    localparam logic [2:0] KIND_PAUSE    = 3'd3;
    localparam logic [2:0] KIND_RESUME   = 3'd4;
    localparam logic [2:0] KIND_CANCEL   = 3'd5;
    localparam logic [2:0] KIND_SET_TEMP = 3'd6;

    typedef enum logic [1:0] {
        SEG_HOLD  = 2'd0,
        SEG_AFAP  = 2'd1,
        SEG_PAUSE = 2'd2,
        SEG_RAMP  = 2'd3
    } seg_type_t;

    typedef struct packed {
        seg_type_t          stype;
        logic signed [15:0] target;
        logic [27:0]        dur;
    } seg_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [31:0]        now_seconds;
        logic signed [15:0] pv;
        logic [1:0]         seg_type;
        logic signed [15:0] seg_temp;
        logic [27:0]        seg_param;
    } item_t;

    typedef struct packed {
        logic [1:0]         cmd_count;
        logic signed [15:0] first_sv;
        logic               first_nonvolatile;
        logic signed [15:0] second_sv;
        logic               second_nonvolatile;
        logic [1:0]         mode;
        logic [15:0]        step_number;
        logic [4:0]         queue_level;
        logic [31:0]        program_seconds;
        logic [31:0]        segment_seconds;
        logic               dropped;
    } result_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DECODE,
        S_APP_MUL,
        S_APP_FIN,
        S_APP_WR,
        S_CK_REACH,
        S_CK_RAMP,
        S_CK_MUL,
        S_CK_NSV,
        S_CK_SVCMP,
        S_CK_HOLD,
        S_PAU_MUL,
        S_PAU_FIX,
        S_PAU_PF1,
        S_PAU_PF2,
        S_SETT1,
        S_SETT2,
        S_SETT3,
        S_NS_BEGIN,
        S_NS_LOAD,
        S_NS_EMIT,
        S_DIV_GO,
        S_DIV_WAIT,
        S_DONE
    } state_t;

    // Magnitude of the difference of two temperatures; it always fits 16 bits.
    function automatic logic [15:0] abs_diff(input logic signed [15:0] a,
                                             input logic signed [15:0] b);
        logic signed [16:0] d;
        logic [16:0]        mag;
        d   = {a[15], a} - {b[15], b};
        mag = d[16] ? 17'(-d) : 17'(d);
        return mag[15:0];
    endfunction

    // Saturate a wide signed value to 16 bits signed.
    function automatic logic [15:0] sat16(input logic [NUM_W+1:0] v);
        logic [15:0] r;
        if (!v[NUM_W+1] && (|v[NUM_W:15]))
            r = 16'h7FFF;
        else if (v[NUM_W+1] && !(&v[NUM_W:15]))
            r = 16'h8000;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

// ----- hw/rtl/rss_if.sv -----
// Handshake channel interfaces of the setpoint sequencer: input items, results, configuration.
interface rss_item_if;
    import rss_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rss_result_if;
    import rss_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface rss_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/rss_div.sv -----
// Restoring serial divider, one quotient bit per cycle, shared by all divisions.
module rss_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [rss_pkg::NUM_W-1:0] num,
    input  logic [rss_pkg::DEN_W-1:0] den,
    output logic [rss_pkg::NUM_W-1:0] quo,
    output logic                      busy,
    output logic                      done
);
    import rss_pkg::*;

    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DEN_W:0]       shifted;
    logic [DEN_W:0]       diff;
    logic                 ge;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign ge      = shifted >= {1'b0, den_reg};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
            cnt_next  = DIV_CNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], ge};
            rem_next = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo  = quo_reg;
    assign busy = busy_reg;
    assign done = done_reg;

endmodule

// ----- hw/rtl/rss_queue.sv -----
// Segment queue storage: one write port and one registered read port.
module rss_queue #(
    parameter int DEPTH = rss_pkg::QUEUE_DEPTH_DEF,
    parameter int PTR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [PTR_W-1:0]  waddr,
    input  rss_pkg::seg_t     wdata,
    input  logic [PTR_W-1:0]  raddr,
    output rss_pkg::seg_t     rdata
);
    import rss_pkg::*;

    seg_t mem [DEPTH];
    seg_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/ramp_soak_setpoint_sequencer_core.sv -----
// Top level of the ramp/soak setpoint sequencer: sequencer, state and result register.
//
//   channel  modport  carries                                   transfer when
//   item     sink     kind, time, pv, appended segment fields   item.valid & item.ready
//   result   source   setpoint commands and status              result.valid & result.ready
//   cfg      sink     margin setting (8 bits)                   cfg.valid & cfg.ready
//
// The longest items are those that run the 48-bit serial divider, such as a sample that ends
// a segment and then interpolates a ramp; items that only report status are the shortest.
// The block takes no new item until the current one has been handed to the result register.
// A pending result waits there while the next item is worked on.
// Reset is asynchronous and needs no clearing pass; queue entries are undefined until written.
module ramp_soak_setpoint_sequencer_core #(
    parameter int QUEUE_DEPTH = rss_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    rss_item_if.sink      item,
    rss_cfg_if.sink       cfg,
    rss_result_if.source  result
);
    import rss_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR   = PTR_W'(QUEUE_DEPTH - 1);

    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    state_t             div_ret_reg, div_ret_next;
    item_t              in_reg, in_next;
    logic [7:0]         margin_reg;
    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    seg_type_t          cur_type_reg, cur_type_next;
    logic signed [15:0] cur_target_reg, cur_target_next;
    logic [27:0]        cur_dur_reg, cur_dur_next;
    logic [31:0]        start_sec_reg, start_sec_next;
    logic signed [15:0] start_temp_reg, start_temp_next;
    logic signed [15:0] setpoint_reg, setpoint_next;
    logic signed [15:0] last_pv_reg, last_pv_next;
    logic signed [15:0] prev_target_reg, prev_target_next;
    logic               firing_reg, firing_next;
    logic [15:0]        step_reg, step_next;
    logic [31:0]        pe_reg, pe_next;
    logic [31:0]        se_reg, se_next;
    logic [1:0]         ncmd_reg, ncmd_next;
    logic signed [15:0] sv0_reg, sv0_next;
    logic               nv0_reg, nv0_next;
    logic signed [15:0] sv1_reg, sv1_next;
    logic               nv1_reg, nv1_next;
    logic               drop_reg, drop_next;
    seg_t               wseg_reg, wseg_next;
    logic [NUM_W-1:0]   prod_reg, prod_next;
    logic [DEN_W-1:0]   den_reg, den_next;
    logic               neg_reg, neg_next;
    logic signed [15:0] nsv_reg, nsv_next;
    result_t            res_reg, res_next;
    logic               out_valid_reg, out_valid_next;

    logic [15:0]        mul_a;
    logic [31:0]        mul_b;
    logic [NUM_W-1:0]   prod;
    logic               div_start;
    logic [NUM_W-1:0]   div_quo;
    logic               div_busy;
    logic               div_done;
    logic               mem_we;
    logic [PTR_W-1:0]   mem_waddr;
    seg_t               mem_wdata;
    seg_t               mem_rdata;

    logic [SUM_W-1:0]   tail_sum;
    logic [PTR_W-1:0]   tail_ptr;
    logic [PTR_W-1:0]   head_inc;
    logic [PTR_W-1:0]   head_dec;
    logic               full;
    logic signed [15:0] app_base;
    logic [31:0]        hold_el;
    logic               hold_over;
    logic [27:0]        hold_rem;
    logic               reach_hit;
    logic [NUM_W+1:0]   q_ext;
    logic [NUM_W+1:0]   q_signed;
    logic [NUM_W+1:0]   interp_sum;
    logic [CNT_W+4:0]   lvl_wide;
    logic               cancel_en;
    logic               emit_en;
    logic signed [15:0] emit_sv;
    logic               emit_nv;

    rss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (prod_reg),
        .den   (den_reg),
        .quo   (div_quo),
        .busy  (div_busy),
        .done  (div_done)
    );

    rss_queue #(
        .DEPTH (QUEUE_DEPTH),
        .PTR_W (PTR_W)
    ) u_queue (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (head_reg),
        .rdata (mem_rdata)
    );

    assign tail_sum  = SUM_W'(head_reg) + SUM_W'(count_reg);
    assign tail_ptr  = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                       PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : PTR_W'(tail_sum);
    assign head_inc  = (head_reg == LAST_PTR) ? '0 : head_reg + 1'b1;
    assign head_dec  = (head_reg == '0) ? LAST_PTR : head_reg - 1'b1;
    assign full      = (count_reg == FULL_COUNT);
    assign app_base  = (count_reg != '0) ? prev_target_reg : last_pv_reg;
    assign hold_el   = in_reg.now_seconds - start_sec_reg;
    assign hold_over = (hold_el >= {4'b0, cur_dur_reg});
    assign hold_rem  = hold_over ? 28'd0 : cur_dur_reg - hold_el[27:0];
    assign reach_hit = ((cur_type_reg == SEG_AFAP) || (cur_type_reg == SEG_RAMP)) &&
                       ({1'b0, abs_diff(last_pv_reg, cur_target_reg)} <= {9'b0, margin_reg});
    assign prod      = mul_a * mul_b;
    assign q_ext     = {2'b00, div_quo};
    assign q_signed  = neg_reg ? (NUM_W+2)'(-q_ext) : q_ext;
    assign interp_sum = q_signed + {{(NUM_W-14){start_temp_reg[15]}}, start_temp_reg};
    assign lvl_wide  = {5'd0, count_reg};

    // Sequencer: next state and return points.
    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        div_ret_next = div_ret_reg;
        case (state_reg)
            S_IDLE:
                if (item.valid)
                    state_next = S_DECODE;
            S_DECODE:
            begin
                ret_next = S_DONE;
                case (in_reg.kind)
                    KIND_PV:
                        state_next = S_CK_REACH;
                    KIND_APPEND:
                        if (full)
                            state_next = S_DONE;
                        else if ((in_reg.seg_type == SEG_RAMP) && (in_reg.seg_param != '0))
                            state_next = S_APP_MUL;
                        else
                            state_next = S_APP_WR;
                    KIND_START, KIND_RESUME:
                        state_next = S_NS_BEGIN;
                    KIND_PAUSE:
                        if (cur_type_reg == SEG_PAUSE)
                            state_next = S_DONE;
                        else if ((cur_type_reg == SEG_RAMP) &&
                                 (cur_target_reg != start_temp_reg))
                            state_next = S_PAU_MUL;
                        else
                            state_next = S_PAU_PF1;
                    KIND_SET_TEMP:
                        state_next = S_SETT1;
                    default:
                        state_next = S_DONE;
                endcase
            end
            S_APP_MUL:
            begin
                div_ret_next = S_APP_FIN;
                state_next   = S_DIV_GO;
            end
            S_APP_FIN:
                state_next = S_APP_WR;
            S_APP_WR:
                state_next = S_DONE;
            S_CK_REACH:
                if (reach_hit)
                begin
                    ret_next   = S_CK_RAMP;
                    state_next = S_NS_BEGIN;
                end
                else
                    state_next = S_CK_RAMP;
            S_CK_RAMP:
                if (cur_type_reg == SEG_RAMP)
                    state_next = (cur_dur_reg == '0) ? S_CK_SVCMP : S_CK_MUL;
                else
                    state_next = S_CK_HOLD;
            S_CK_MUL:
            begin
                div_ret_next = S_CK_NSV;
                state_next   = S_DIV_GO;
            end
            S_CK_NSV:
                state_next = S_CK_SVCMP;
            S_CK_SVCMP:
                state_next = S_CK_HOLD;
            S_CK_HOLD:
                if ((cur_type_reg == SEG_HOLD) && hold_over)
                begin
                    ret_next   = S_DONE;
                    state_next = S_NS_BEGIN;
                end
                else
                    state_next = S_DONE;
            S_PAU_MUL:
            begin
                div_ret_next = S_PAU_FIX;
                state_next   = S_DIV_GO;
            end
            S_PAU_FIX:
                state_next = S_PAU_PF1;
            S_PAU_PF1:
                state_next = S_PAU_PF2;
            S_PAU_PF2:
                state_next = S_NS_BEGIN;
            S_SETT1:
                state_next = S_SETT2;
            S_SETT2:
                state_next = S_SETT3;
            S_SETT3:
                state_next = S_NS_BEGIN;
            S_NS_BEGIN:
                state_next = (count_reg != '0) ? S_NS_LOAD : S_NS_EMIT;
            S_NS_LOAD:
                state_next = S_NS_EMIT;
            S_NS_EMIT:
                state_next = ret_reg;
            S_DIV_GO:
                state_next = S_DIV_WAIT;
            S_DIV_WAIT:
                if (div_done)
                    state_next = div_ret_reg;
            S_DONE:
                if (!out_valid_reg || result.ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath updates driven by the sequencer state.
    always_comb
    begin
        in_next          = in_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        cur_type_next    = cur_type_reg;
        cur_target_next  = cur_target_reg;
        cur_dur_next     = cur_dur_reg;
        start_sec_next   = start_sec_reg;
        start_temp_next  = start_temp_reg;
        setpoint_next    = setpoint_reg;
        last_pv_next     = last_pv_reg;
        prev_target_next = prev_target_reg;
        firing_next      = firing_reg;
        step_next        = step_reg;
        pe_next          = pe_reg;
        se_next          = se_reg;
        ncmd_next        = ncmd_reg;
        sv0_next         = sv0_reg;
        nv0_next         = nv0_reg;
        sv1_next         = sv1_reg;
        nv1_next         = nv1_reg;
        drop_next        = drop_reg;
        wseg_next        = wseg_reg;
        prod_next        = prod_reg;
        den_next         = den_reg;
        neg_next         = neg_reg;
        nsv_next         = nsv_reg;
        res_next         = res_reg;
        out_valid_next   = out_valid_reg;
        mul_a            = '0;
        mul_b            = '0;
        div_start        = 1'b0;
        mem_we           = 1'b0;
        mem_waddr        = tail_ptr;
        mem_wdata        = wseg_reg;
        cancel_en        = 1'b0;
        emit_en          = 1'b0;
        emit_sv          = '0;
        emit_nv          = 1'b0;

        if (out_valid_reg && result.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
                if (item.valid)
                begin
                    in_next   = item.data;
                    ncmd_next = '0;
                    sv0_next  = '0;
                    nv0_next  = 1'b0;
                    sv1_next  = '0;
                    nv1_next  = 1'b0;
                    drop_next = 1'b0;
                end
            S_DECODE:
                case (in_reg.kind)
                    KIND_PV:
                    begin
                        last_pv_next = in_reg.pv;
                        se_next      = in_reg.now_seconds - start_sec_reg;
                    end
                    KIND_APPEND:
                        if (full)
                            drop_next = 1'b1;
                        else
                        begin
                            wseg_next.stype  = seg_type_t'(in_reg.seg_type);
                            wseg_next.target = in_reg.seg_temp;
                            wseg_next.dur    = '0;
                            if (in_reg.seg_type == SEG_HOLD)
                            begin
                                wseg_next.target = app_base;
                                wseg_next.dur    = in_reg.seg_param;
                            end
                            else if (in_reg.seg_type == SEG_PAUSE)
                                wseg_next.target = app_base;
                        end
                    KIND_START:
                    begin
                        emit_en         = 1'b1;
                        emit_nv         = 1'b1;
                        cur_type_next   = SEG_PAUSE;
                        cur_target_next = '0;
                        cur_dur_next    = '0;
                        start_sec_next  = in_reg.now_seconds;
                        start_temp_next = last_pv_reg;
                        firing_next     = 1'b1;
                        step_next       = '0;
                        pe_next         = '0;
                        se_next         = '0;
                    end
                    KIND_PAUSE:
                    begin
                        wseg_next.stype  = cur_type_reg;
                        wseg_next.target = cur_target_reg;
                        wseg_next.dur    = cur_dur_reg;
                        if (cur_type_reg == SEG_HOLD)
                            wseg_next.dur = hold_rem;
                        else if (cur_type_reg == SEG_RAMP)
                            wseg_next.dur = '0;
                    end
                    KIND_CANCEL, KIND_SET_TEMP:
                        cancel_en = 1'b1;
                    default:
                    begin
                    end
                endcase
            S_APP_MUL:
            begin
                mul_a     = abs_diff(in_reg.seg_temp, app_base);
                mul_b     = 32'(SECONDS_PER_HOUR);
                prod_next = prod;
                den_next  = in_reg.seg_param;
                neg_next  = 1'b0;
            end
            S_APP_FIN:
                wseg_next.dur = div_quo[DEN_W-1:0];
            S_APP_WR:
            begin
                mem_we           = 1'b1;
                count_next       = count_reg + 1'b1;
                prev_target_next = wseg_reg.target;
            end
            S_CK_RAMP:
                nsv_next = cur_target_reg;
            S_CK_MUL:
            begin
                mul_a     = abs_diff(cur_target_reg, start_temp_reg);
                mul_b     = in_reg.now_seconds - start_sec_reg;
                prod_next = prod;
                den_next  = cur_dur_reg;
                neg_next  = (cur_target_reg < start_temp_reg);
            end
            S_CK_NSV:
                nsv_next = sat16(interp_sum);
            S_CK_SVCMP:
                if (abs_diff(nsv_reg, setpoint_reg) >= {8'b0, margin_reg})
                begin
                    emit_en = 1'b1;
                    emit_sv = nsv_reg;
                end
            S_PAU_MUL:
            begin
                mul_a     = abs_diff(cur_target_reg, setpoint_reg);
                mul_b     = {4'b0, cur_dur_reg};
                prod_next = prod;
                den_next  = DEN_W'(abs_diff(cur_target_reg, start_temp_reg));
                neg_next  = (cur_target_reg < setpoint_reg) ^ (cur_target_reg < start_temp_reg);
            end
            S_PAU_FIX:
                // Negative ratios clamp to zero and ratios above one to the full duration.
                if (neg_reg && (div_quo != '0))
                    wseg_next.dur = '0;
                else if (div_quo > NUM_W'(cur_dur_reg))
                    wseg_next.dur = cur_dur_reg;
                else
                    wseg_next.dur = div_quo[DEN_W-1:0];
            S_PAU_PF1, S_PAU_PF2:
            begin
                mem_we    = 1'b1;
                mem_waddr = head_dec;
                head_next = head_dec;
                if (state_reg == S_PAU_PF2)
                begin
                    mem_wdata.stype  = SEG_PAUSE;
                    mem_wdata.target = last_pv_reg;
                    mem_wdata.dur    = '0;
                end
                // A front insertion into a full queue overwrites the tail entry.
                if (full)
                    drop_next = 1'b1;
                else
                    count_next = count_reg + 1'b1;
            end
            S_SETT1, S_SETT2, S_SETT3:
            begin
                mem_we           = 1'b1;
                count_next       = count_reg + 1'b1;
                mem_wdata.stype  = SEG_AFAP;
                mem_wdata.target = in_reg.seg_temp;
                mem_wdata.dur    = '0;
                if (state_reg == S_SETT2)
                    mem_wdata.stype = SEG_PAUSE;
                if (state_reg == S_SETT3)
                begin
                    mem_wdata.target = '0;
                    firing_next      = 1'b1;
                    step_next        = '0;
                end
            end
            S_NS_BEGIN:
            begin
                pe_next = pe_reg + se_reg;
                se_next = '0;
                if (count_reg == '0)
                    cancel_en = 1'b1;
            end
            S_NS_LOAD:
            begin
                cur_type_next   = mem_rdata.stype;
                cur_target_next = mem_rdata.target;
                cur_dur_next    = mem_rdata.dur;
                head_next       = head_inc;
                count_next      = count_reg - 1'b1;
            end
            S_NS_EMIT:
            begin
                if ((cur_type_reg == SEG_AFAP) ||
                    ((cur_type_reg == SEG_PAUSE) && (cur_target_reg != '0)))
                begin
                    emit_en = 1'b1;
                    emit_sv = cur_target_reg;
                end
                if (firing_reg)
                    step_next = step_reg + 1'b1;
                start_sec_next  = in_reg.now_seconds;
                start_temp_next = last_pv_reg;
            end
            S_DIV_GO:
                div_start = 1'b1;
            S_DONE:
                if (!out_valid_reg || result.ready)
                begin
                    res_next.cmd_count          = ncmd_reg;
                    res_next.first_sv           = sv0_reg;
                    res_next.first_nonvolatile  = nv0_reg;
                    res_next.second_sv          = sv1_reg;
                    res_next.second_nonvolatile = nv1_reg;
                    res_next.mode               = cur_type_reg;
                    res_next.step_number        = step_reg;
                    res_next.queue_level        = lvl_wide[4:0];
                    res_next.program_seconds    = pe_reg;
                    res_next.segment_seconds    = se_reg;
                    res_next.dropped            = drop_reg;
                    out_valid_next              = 1'b1;
                end
            default:
            begin
            end
        endcase

        // Cancelling empties the queue, ends the firing and parks the setpoint at zero.
        if (cancel_en)
        begin
            count_next      = '0;
            head_next       = '0;
            firing_next     = 1'b0;
            step_next       = '0;
            se_next         = '0;
            pe_next         = '0;
            cur_type_next   = SEG_PAUSE;
            cur_target_next = '0;
            cur_dur_next    = '0;
            start_sec_next  = in_reg.now_seconds;
            start_temp_next = last_pv_reg;
            emit_en         = 1'b1;
            emit_sv         = '0;
            emit_nv         = 1'b1;
        end

        // Every command moves the setpoint; only the first two are reported.
        if (emit_en)
        begin
            setpoint_next = emit_sv;
            if (ncmd_reg == 2'd0)
            begin
                sv0_next  = emit_sv;
                nv0_next  = emit_nv;
                ncmd_next = 2'd1;
            end
            else if (ncmd_reg == 2'd1)
            begin
                sv1_next  = emit_sv;
                nv1_next  = emit_nv;
                ncmd_next = 2'd2;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            ret_reg         <= S_DONE;
            div_ret_reg     <= S_DONE;
            margin_reg      <= MARGIN_RESET;
            head_reg        <= '0;
            count_reg       <= '0;
            cur_type_reg    <= SEG_PAUSE;
            cur_target_reg  <= '0;
            cur_dur_reg     <= '0;
            start_sec_reg   <= '0;
            start_temp_reg  <= '0;
            setpoint_reg    <= '0;
            last_pv_reg     <= -16'sd1;
            prev_target_reg <= '0;
            firing_reg      <= 1'b0;
            step_reg        <= '0;
            pe_reg          <= '0;
            se_reg          <= '0;
            ncmd_reg        <= '0;
            sv0_reg         <= '0;
            nv0_reg         <= 1'b0;
            sv1_reg         <= '0;
            nv1_reg         <= 1'b0;
            drop_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            ret_reg         <= ret_next;
            div_ret_reg     <= div_ret_next;
            if (cfg.valid && cfg.ready)
                margin_reg  <= cfg.data;
            head_reg        <= head_next;
            count_reg       <= count_next;
            cur_type_reg    <= cur_type_next;
            cur_target_reg  <= cur_target_next;
            cur_dur_reg     <= cur_dur_next;
            start_sec_reg   <= start_sec_next;
            start_temp_reg  <= start_temp_next;
            setpoint_reg    <= setpoint_next;
            last_pv_reg     <= last_pv_next;
            prev_target_reg <= prev_target_next;
            firing_reg      <= firing_next;
            step_reg        <= step_next;
            pe_reg          <= pe_next;
            se_reg          <= se_next;
            ncmd_reg        <= ncmd_next;
            sv0_reg         <= sv0_next;
            nv0_reg         <= nv0_next;
            sv1_reg         <= sv1_next;
            nv1_reg         <= nv1_next;
            drop_reg        <= drop_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg   <= in_next;
        wseg_reg <= wseg_next;
        prod_reg <= prod_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        nsv_reg  <= nsv_next;
        res_reg  <= res_next;
    end

    // The margin is only taken between items, so no item sees it change midway.
    assign item.ready   = (state_reg == S_IDLE);
    assign cfg.ready    = (state_reg == S_IDLE);
    assign result.valid = out_valid_reg;
    assign result.data  = res_reg;

    a_ncmd_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ncmd_reg != 2'd3)
        else $error("more than two setpoint commands recorded");

    a_count_limit: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("queue count beyond depth");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV_GO) |=> div_busy)
        else $error("divider not running after start");

endmodule
